// File: hdl/sdss_pkg.sv
// Shared types, constants and segment encoding for the signed decimal display encoder.
`default_nettype none
package sdss_pkg;

  localparam int SDSS_DIGIT_COUNT = 8;
  localparam int SDSS_MAG_W       = 32;
  localparam int SDSS_BCD_DIGITS  = 10;
  localparam int SDSS_BCD_W       = 4 * SDSS_BCD_DIGITS;
  localparam int SDSS_OUT_POS     = 8;
  localparam int SDSS_STEP_W      = $clog2(SDSS_MAG_W);

  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [3:0]  point_pos;
  } sdss_in_t;

  typedef struct packed {
    logic [7:0] seg_0;
    logic [7:0] seg_1;
    logic [7:0] seg_2;
    logic [7:0] seg_3;
    logic [7:0] seg_4;
    logic [7:0] seg_5;
    logic [7:0] seg_6;
    logic [7:0] seg_7;
    logic       overflow;
  } sdss_out_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sdss_dabble.sv
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`default_nettype none
module sdss_dabble
  import sdss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic [SDSS_MAG_W-1:0] mag,
  output logic                       done,
  output logic [SDSS_BCD_W-1:0]      bcd
);

  logic [SDSS_MAG_W-1:0]  bin_r, bin_nxt;
  logic [SDSS_BCD_W-1:0]  bcd_r, bcd_nxt, adj;
  logic [SDSS_STEP_W-1:0] cnt_r, cnt_nxt;
  logic                   run_r, run_nxt;
  logic                   done_r, done_nxt;

  always_comb begin
    for (int d = 0; d < SDSS_BCD_DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {adj[SDSS_BCD_W-2:0], bin_r[SDSS_MAG_W-1]};
      bin_nxt = {bin_r[SDSS_MAG_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == SDSS_STEP_W'(SDSS_MAG_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule
`default_nettype wire

// File: hdl/sdss_format.sv
// Places BCD digits, minus sign and decimal point into the display positions.
`default_nettype none
module sdss_format
  import sdss_pkg::*;
#(
  parameter int DIGIT_COUNT = SDSS_DIGIT_COUNT
) (
  input  wire logic [SDSS_BCD_W-1:0] bcd,
  input  wire logic                  negative,
  input  wire logic [3:0]            point_pos,
  output sdss_out_t                  word
);

  localparam logic [4:0] DC = 5'(DIGIT_COUNT);

  logic [3:0] ndig;
  logic [4:0] nchar;
  logic [7:0] pos [SDSS_OUT_POS];
  logic       pnt_on;

  always_comb begin
    ndig = 4'd1;
    for (int i = 1; i < SDSS_BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) ndig = 4'(i + 1);
    end
  end

  assign nchar  = {1'b0, ndig} + {4'd0, negative};
  assign pnt_on = !point_pos[3] && ({1'b0, point_pos} < DC);

  always_comb begin
    for (int k = 0; k < SDSS_OUT_POS; k++) begin
      pos[k] = 8'h00;
      if (k < DIGIT_COUNT) begin
        if (4'(k) < ndig) pos[k] = digit_seg(bcd[4*k +: 4]);
        else if (negative && 4'(k) == ndig) pos[k] = SEG_MINUS;
        if (pnt_on && point_pos[2:0] == 3'(k)) pos[k] = pos[k] | SEG_POINT;
      end
    end
  end

  always_comb begin
    word.seg_0    = pos[0];
    word.seg_1    = pos[1];
    word.seg_2    = pos[2];
    word.seg_3    = pos[3];
    word.seg_4    = pos[4];
    word.seg_5    = pos[5];
    word.seg_6    = pos[6];
    word.seg_7    = pos[7];
    word.overflow = nchar > DC;
  end

endmodule
`default_nettype wire

// File: hdl/signed_decimal_to_seven_segment_unit.sv
// Top level: signed binary to seven-segment display word encoder.
//
// Usage:
//   Drive in_data and raise start; the word is taken at a rising edge where
//   start is high and busy is low. busy then stays high while the value is
//   converted. One result word appears on out_data for exactly one cycle,
//   marked by out_valid; there is no back-pressure, the receiver must take it.
// Conversion:
//   The magnitude goes through a shift-and-add-3 BCD converter one bit per
//   cycle, then a register captures the formatted word as out_valid rises.
//   busy falls in the out_valid cycle, so a new word can be taken then;
//   no new word is taken while the converter loop is still running.
// Reset:
//   rst_n is synchronous, active low; it clears busy and out_valid and
//   abandons any conversion in flight.
`default_nettype none
module signed_decimal_to_seven_segment_unit
  import sdss_pkg::*;
#(
  parameter int DIGIT_COUNT = SDSS_DIGIT_COUNT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire sdss_in_t in_data,
  output logic          busy,
  output logic          out_valid,
  output sdss_out_t     out_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CONV = 1'b1;

  logic                  state_r, state_nxt;
  logic                  neg_r;
  logic [3:0]            pnt_r;
  logic                  out_valid_r;
  sdss_out_t             out_data_r;
  logic                  accept;
  logic [SDSS_MAG_W-1:0] mag;
  logic                  conv_done;
  logic [SDSS_BCD_W-1:0] bcd;
  sdss_out_t             fmt_word;

  assign accept = start && (state_r == ST_IDLE);
  assign mag    = in_data.value[31] ? (32'd0 - in_data.value) : in_data.value;

  sdss_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  sdss_format #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_format (
    .bcd       (bcd),
    .negative  (neg_r),
    .point_pos (pnt_r),
    .word      (fmt_word)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CONV;
      ST_CONV: if (conv_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= conv_done && (state_r == ST_CONV);
    end
    if (accept) begin
      neg_r <= in_data.value[31];
      pnt_r <= in_data.point_pos;
    end
    if (conv_done) out_data_r <= fmt_word;
  end

  assign busy      = (state_r == ST_CONV);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: hdl/sdss_checker.sv
// Port-level checker for the display encoder, bound to the top level.
`default_nettype none
module sdss_checker
  import sdss_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire sdss_out_t out_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy |=> busy)
    else $error("busy did not rise after an accepted word");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_units_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.seg_0[6:0] != 7'h00))
    else $error("units digit blank in result word");

endmodule

bind signed_decimal_to_seven_segment_unit sdss_checker u_sdss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/signed_decimal_to_seven_segment_unit_tb.sv
// Self-checking testbench for the signed decimal to seven-segment display encoder.
`timescale 1ns / 100ps
module signed_decimal_to_seven_segment_unit_tb;
  import sdss_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [79:0] DIGIT_SEGS = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                        8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

  typedef struct packed {
    sdss_in_t  src;
    sdss_out_t segs;
  } due_word_t;

  typedef struct packed {
    sdss_in_t  src;
    logic      typed;
    sdss_out_t segs;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  sdss_in_t  in_data;
  logic      busy;
  logic      out_valid;
  sdss_out_t out_data;

  due_word_t words_due[$];
  stim_row_t stim_rows[$];
  int        error_count;
  int        cycle_count;

  signed_decimal_to_seven_segment_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic sdss_out_t encode_display(sdss_in_t w);
    logic [7:0]  pos [16];
    logic [31:0] mag;
    logic [31:0] digit;
    int          n;
    logic        ovf;
    sdss_out_t   r;
    for (int k = 0; k < 16; k++) pos[k] = 8'h00;
    mag = w.value[31] ? 32'd0 - 32'(w.value) : 32'(w.value);
    n   = 0;
    ovf = 1'b0;
    do begin
      digit = mag % 32'd10;
      if (n < SDSS_DIGIT_COUNT) pos[n] = DIGIT_SEGS[8 * digit[3:0] +: 8];
      else ovf = 1'b1;
      mag = mag / 32'd10;
      n++;
    end while (mag != 32'd0);
    if (w.value[31]) begin
      if (n < SDSS_DIGIT_COUNT) pos[n] = SEG_MINUS;
      else ovf = 1'b1;
    end
    if (!w.point_pos[3] && 32'(w.point_pos) < SDSS_DIGIT_COUNT &&
        32'(w.point_pos) < SDSS_OUT_POS)
      pos[w.point_pos[2:0]] = pos[w.point_pos[2:0]] | SEG_POINT;
    r.seg_0    = pos[0];
    r.seg_1    = pos[1];
    r.seg_2    = pos[2];
    r.seg_3    = pos[3];
    r.seg_4    = pos[4];
    r.seg_5    = pos[5];
    r.seg_6    = pos[6];
    r.seg_7    = pos[7];
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, sdss_in_t src, logic [7:0] got,
                                 logic [7:0] want);
    $display("ERROR: %s value=%0d point=%0d got=%02h want=%02h", what,
             src.value, src.point_pos, got, want);
    error_count++;
  endtask

  task automatic check_field(string name, sdss_in_t src, logic [7:0] got,
                             logic [7:0] want);
    if (got !== want) report_mismatch(name, src, got, want);
  endtask

  always @(posedge clk) begin
    due_word_t d;
    if (rst_n && out_valid) begin
      if (words_due.size() == 0) begin
        report_mismatch("word with none due", '0, out_data.seg_0, 8'h00);
      end else begin
        d = words_due.pop_front();
        check_field("seg_0", d.src, out_data.seg_0, d.segs.seg_0);
        check_field("seg_1", d.src, out_data.seg_1, d.segs.seg_1);
        check_field("seg_2", d.src, out_data.seg_2, d.segs.seg_2);
        check_field("seg_3", d.src, out_data.seg_3, d.segs.seg_3);
        check_field("seg_4", d.src, out_data.seg_4, d.segs.seg_4);
        check_field("seg_5", d.src, out_data.seg_5, d.segs.seg_5);
        check_field("seg_6", d.src, out_data.seg_6, d.segs.seg_6);
        check_field("seg_7", d.src, out_data.seg_7, d.segs.seg_7);
        check_field("overflow", d.src, 8'(out_data.overflow), 8'(d.segs.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_decimal_to_seven_segment_unit regression: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(sdss_in_t w, sdss_out_t want);
    due_word_t d;
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    d.src  = w;
    d.segs = want;
    words_due.push_back(d);
    @(negedge clk);
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  task automatic add_row(logic signed [31:0] v, logic signed [3:0] p, logic typed,
                         sdss_out_t segs);
    stim_row_t r;
    r.src.value     = v;
    r.src.point_pos = p;
    r.typed         = typed;
    r.segs          = segs;
    stim_rows.push_back(r);
  endtask

  function automatic sdss_in_t random_word();
    sdss_in_t w;
    longint   lo;
    longint   hi;
    longint   mag;
    int       n;
    n  = $urandom_range(1, 10);
    lo = (n == 1) ? 0 : 1;
    hi = 1;
    for (int k = 0; k < n; k++) hi = hi * 10;
    for (int k = 1; k < n; k++) lo = lo * 10;
    hi = hi - 1;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    case ($urandom_range(0, 3))
      0: mag = longint'($urandom);
      3: mag = $urandom_range(1) ? hi : lo;
      default: mag = lo + longint'($urandom) % (hi - lo + 1);
    endcase
    w.value = 32'(mag);
    if ($urandom_range(1) && mag <= 64'sd2147483647) w.value = -w.value;
    if ($urandom_range(1)) w.point_pos = 4'($urandom_range(0, 15));
    else w.point_pos = $urandom_range(3) == 0 ? -4'sd1 : 4'($urandom_range(0, 7));
    return w;
  endfunction

  initial begin
    sdss_in_t w;
    int       pct;
    error_count = 0;
    cycle_count = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;

    add_row(0, -1, 1, '{8'h3f, 0, 0, 0, 0, 0, 0, 0, 1'b0});
    add_row(0, 0, 1, '{8'hbf, 0, 0, 0, 0, 0, 0, 0, 1'b0});
    add_row(1, 7, 1, '{8'h06, 0, 0, 0, 0, 0, 0, 8'h80, 1'b0});
    add_row(-1, -1, 1, '{8'h06, 8'h40, 0, 0, 0, 0, 0, 0, 1'b0});
    add_row(7, -8, 1, '{8'h07, 0, 0, 0, 0, 0, 0, 0, 1'b0});
    add_row(7, -2, 1, '{8'h07, 0, 0, 0, 0, 0, 0, 0, 1'b0});
    add_row(32'sh7fffffff, -1, 1,
            '{8'h07, 8'h66, 8'h7d, 8'h4f, 8'h7f, 8'h66, 8'h07, 8'h66, 1'b1});
    add_row(32'sh80000000, -1, 1,
            '{8'h7f, 8'h66, 8'h7d, 8'h4f, 8'h7f, 8'h66, 8'h07, 8'h66, 1'b1});
    add_row(99999999, 3, 0, '0);
    add_row(100000000, 0, 0, '0);
    add_row(-9999999, 7, 0, '0);
    add_row(-10000000, -1, 0, '0);
    add_row(12345678, 1, 0, '0);
    add_row(90817263, 2, 0, '0);
    add_row(-45, 4, 0, '0);
    add_row(10, 5, 0, '0);
    add_row(1000000000, 6, 0, '0);
    add_row(-999999999, 0, 0, '0);
    add_row(5, 6, 0, '0);
    add_row(-123, 1, 0, '0);
    add_row(-2, 3, 0, '0);
    add_row(32'sh80000001, 7, 0, '0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].src,
                stim_rows[i].typed ? stim_rows[i].segs : encode_display(stim_rows[i].src));
      idle_gap(30);
    end

    // phases: no idling, sender idle half the time, sender idle 24 percent of the time
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case (i * 3 / RANDOM_WORDS)
        0: pct = 0;
        1: pct = 50;
        default: pct = 24;
      endcase
      w = random_word();
      send_word(w, encode_display(w));
      idle_gap(pct);
    end
    start <= 1'b0;

    while (words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("signed_decimal_to_seven_segment_unit regression: pass");
    end else begin
      $display("signed_decimal_to_seven_segment_unit regression: fail");
    end
    $finish;
  end

endmodule
